>>> hw/rtl/spm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the string pattern matcher.
package spm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int PAT_BYTES       = 32;
    localparam int LEN_W           = 6;
    localparam int MODE_W          = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int COUNT_W         = 16;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CONTAINS = 3'd0,
        MODE_WORD     = 3'd1,
        MODE_BEGINS   = 3'd2,
        MODE_ENDS     = 3'd3,
        MODE_EQUALS   = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW    = 3'd0,
        REG_PAT_SECOND = 3'd1,
        REG_PAT_THIRD  = 3'd2,
        REG_PAT_HIGH   = 3'd3,
        REG_PAT_LEN    = 3'd4,
        REG_MODE       = 3'd5,
        REG_NEGATE     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic alnum;
        logic last;
        logic empty;
    } spm_item_t;

    function automatic int pat_cap(input int pattern_max);
        return (pattern_max < PAT_BYTES) ? pattern_max : PAT_BYTES;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

endpackage

>>> hw/rtl/spm_in_if.sv
`timescale 1ns / 1ps
// Subject byte channel: valid/ready handshake with one subject byte per transaction.
interface spm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] subject_byte;
    logic       last_byte;
    logic       empty_subject;

    modport source (output valid, output subject_byte, output last_byte,
                    output empty_subject, input ready);
    modport sink   (input valid, input subject_byte, input last_byte,
                    input empty_subject, output ready);
endinterface

>>> hw/rtl/spm_out_if.sv
`timescale 1ns / 1ps
// Match result channel: valid/ready handshake with one decision per transaction.
interface spm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

>>> hw/rtl/spm_front.sv
`timescale 1ns / 1ps
// Front end: accepts subject bytes and classifies them against the pattern.
module spm_front
    import spm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    spm_in_if.sink                          subject,
    input  logic [PAT_BYTES*8-1:0]          pattern,
    input  logic [LEN_W-1:0]                pat_len,
    input  logic                            queue_full,
    output logic                            push,
    output logic [pat_cap(PATTERN_MAX)-1:0] push_eq,
    output spm_item_t                       push_item
);

    localparam int CAP = pat_cap(PATTERN_MAX);

    assign subject.ready = !queue_full;
    assign push          = subject.valid && subject.ready;

    always_comb
    begin
        for (int k = 0; k < CAP; k++)
        begin
            push_eq[k] = (pattern[k*8 +: 8] == subject.subject_byte) &&
                         (LEN_W'(k) < pat_len);
        end
        push_item.alnum = is_alnum(subject.subject_byte);
        push_item.last  = subject.last_byte;
        push_item.empty = subject.empty_subject;
    end

endmodule

>>> hw/rtl/spm_queue.sv
`timescale 1ns / 1ps
// Short FIFO between the front end and the back end.
module spm_queue
    import spm_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/spm_back.sv
`timescale 1ns / 1ps
// Back end: shift-and match state, per-string flags and the registered decision.
module spm_back
    import spm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [pat_cap(PATTERN_MAX)-1:0] q_eq,
    input  spm_item_t                       q_item,
    input  logic [LEN_W-1:0]                pat_len,
    input  logic [MODE_W-1:0]               mode,
    input  logic                            negate,
    output logic                            pop,
    spm_out_if.source                       result
);

    localparam int CAP = pat_cap(PATTERN_MAX);

    logic [CAP-1:0]     pmv_reg, pmv_next;
    logic               prev_alnum_reg, prev_alnum_next;
    logic               wep_reg, wep_next;
    logic               found_reg, found_next;
    logic               prefix_ok_reg, prefix_ok_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               out_valid_reg, out_valid_next;
    logic               matched_reg, matched_next;

    logic               done;
    logic               out_free;
    logic               inject;
    logic [CAP-1:0]     pmv_step;
    logic [CAP-1:0]     len_sel;
    logic [CAP-1:0]     cnt_sel;
    logic               tail_step;
    logic               prefix_step;
    logic               found_step;
    logic               wep_step;
    logic [COUNT_W-1:0] count_step;
    logic               d_found, d_wep, d_prefix, d_tail;
    logic [COUNT_W-1:0] d_len;
    logic               m_zero, m_gt;
    logic               decision;

    assign done     = q_item.empty || q_item.last;
    assign out_free = !out_valid_reg || result.ready;
    assign pop      = q_valid && (!done || out_free);

    assign result.valid   = out_valid_reg;
    assign result.matched = matched_reg;

    always_comb
    begin
        for (int k = 0; k < CAP; k++)
        begin
            len_sel[k] = (pat_len == LEN_W'(k + 1));
            cnt_sel[k] = (byte_count_reg == COUNT_W'(k));
        end
        inject      = (mode == MODE_WORD) ? !prev_alnum_reg : 1'b1;
        pmv_step    = ((pmv_reg << 1) | CAP'(inject)) & q_eq;
        tail_step   = |(pmv_step & len_sel);
        prefix_step = prefix_ok_reg &&
                      !((byte_count_reg < COUNT_W'(pat_len)) && !(|(q_eq & cnt_sel)));
        if (mode == MODE_WORD)
        begin
            found_step = found_reg || (wep_reg && !q_item.alnum);
            wep_step   = tail_step;
        end
        else
        begin
            found_step = found_reg || tail_step;
            wep_step   = wep_reg;
        end
        count_step = (byte_count_reg == '1) ? byte_count_reg : byte_count_reg + 1'b1;

        if (q_item.empty)
        begin
            d_found  = 1'b0;
            d_wep    = 1'b0;
            d_prefix = 1'b1;
            d_tail   = 1'b0;
            d_len    = '0;
        end
        else
        begin
            d_found  = found_step;
            d_wep    = wep_step;
            d_prefix = prefix_step;
            d_tail   = tail_step;
            d_len    = count_step;
        end
        m_zero = (pat_len == '0);
        m_gt   = (COUNT_W'(pat_len) > d_len);

        case (mode)
            MODE_WORD:
            begin
                if (m_zero)
                begin
                    decision = !negate;
                end
                else if (m_gt)
                begin
                    decision = negate;
                end
                else
                begin
                    decision = (d_found || d_wep) ^ negate;
                end
            end
            MODE_EQUALS:
            begin
                decision = !q_item.empty && (d_len == COUNT_W'(pat_len)) && (d_prefix ^ negate);
            end
            MODE_CONTAINS:
            begin
                decision = !q_item.empty && (m_gt ? negate : ((m_zero || d_found) ^ negate));
            end
            MODE_BEGINS:
            begin
                decision = !q_item.empty && (m_gt ? negate : (d_prefix ^ negate));
            end
            MODE_ENDS:
            begin
                decision = !q_item.empty && (m_gt ? negate : ((m_zero || d_tail) ^ negate));
            end
            default:
            begin
                decision = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pmv_next        = pmv_reg;
        prev_alnum_next = prev_alnum_reg;
        wep_next        = wep_reg;
        found_next      = found_reg;
        prefix_ok_next  = prefix_ok_reg;
        byte_count_next = byte_count_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        matched_next    = matched_reg;
        if (pop)
        begin
            if (done)
            begin
                pmv_next        = '0;
                prev_alnum_next = 1'b0;
                wep_next        = 1'b0;
                found_next      = 1'b0;
                prefix_ok_next  = 1'b1;
                byte_count_next = '0;
                out_valid_next  = 1'b1;
                matched_next    = decision;
            end
            else
            begin
                pmv_next        = pmv_step;
                prev_alnum_next = q_item.alnum;
                wep_next        = wep_step;
                found_next      = found_step;
                prefix_ok_next  = prefix_step;
                byte_count_next = count_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmv_reg        <= '0;
            prev_alnum_reg <= 1'b0;
            wep_reg        <= 1'b0;
            found_reg      <= 1'b0;
            prefix_ok_reg  <= 1'b1;
            byte_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pmv_reg        <= pmv_next;
            prev_alnum_reg <= prev_alnum_next;
            wep_reg        <= wep_next;
            found_reg      <= found_next;
            prefix_ok_reg  <= prefix_ok_next;
            byte_count_reg <= byte_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop && done |=> out_valid_reg)
        else $error("finished string did not produce a result");

    a_done_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        pop && done |=> (pmv_reg == '0) && (byte_count_reg == '0) && prefix_ok_reg)
        else $error("per-string state not cleared after string end");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop && done))
        else $error("result raised without a finishing transaction");

    a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !done |=> byte_count_reg != '0)
        else $error("byte count did not advance on a mid-string byte");

endmodule

>>> hw/rtl/string_pattern_match_operator_unit.sv
`timescale 1ns / 1ps
// Top level of the streaming string pattern matcher.
//
// The unit takes one subject byte per transaction and sustains one transaction per
// clock cycle while no finished string waits for its result to be taken: the front end
// compares each byte against all pattern bytes at once, a two-entry FIFO decouples it
// from the back end, and the back end advances a bit-parallel shift-and vector of
// min(PATTERN_MAX, 32) bits by one byte per cycle while the FIFO holds bytes.
// The decision for a string is loaded into the result register that drives the result
// channel when the back end pops its last (or empty-subject) transaction, so input
// keeps flowing while a result waits to be taken. The user must write registers through
// cfg_we/cfg_index/cfg_data only while no string is in flight; the unit does not enforce it.
module string_pattern_match_operator_unit
    import spm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    spm_in_if.sink                subject,
    spm_out_if.source             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CAP    = pat_cap(PATTERN_MAX);
    localparam int ITEM_W = $bits(spm_item_t);
    localparam int Q_W    = CAP + ITEM_W;

    logic [PAT_BYTES*8-1:0] pattern_reg;
    logic [LEN_W-1:0]       pattern_length_reg;
    logic [MODE_W-1:0]      match_mode_reg;
    logic                   negate_result_reg;
    logic [LEN_W-1:0]       pat_len;

    logic                   push;
    logic [CAP-1:0]         push_eq;
    spm_item_t              push_item;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_valid;
    logic [Q_W-1:0]         head_data;
    logic [CAP-1:0]         head_eq;
    spm_item_t              head_item;

    assign pat_len   = (pattern_length_reg > LEN_W'(CAP)) ? LEN_W'(CAP) : pattern_length_reg;
    assign head_eq   = head_data[Q_W-1:ITEM_W];
    assign head_item = spm_item_t'(head_data[ITEM_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg        <= '0;
            pattern_length_reg <= '0;
            match_mode_reg     <= '0;
            negate_result_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAT_LOW:    pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_SECOND: pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_THIRD:  pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_HIGH:   pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_LEN:    pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_MODE:       match_mode_reg     <= cfg_data[MODE_W-1:0];
                REG_NEGATE:     negate_result_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    spm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .subject    (subject),
        .pattern    (pattern_reg),
        .pat_len    (pat_len),
        .queue_full (queue_full),
        .push       (push),
        .push_eq    (push_eq),
        .push_item  (push_item)
    );

    spm_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_eq, push_item}),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head_data (head_data)
    );

    spm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (queue_valid),
        .q_eq    (head_eq),
        .q_item  (head_item),
        .pat_len (pat_len),
        .mode    (match_mode_reg),
        .negate  (negate_result_reg),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> tb/string_pattern_match_operator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming string pattern match unit.
module string_pattern_match_operator_unit_tb;
    import spm_pkg::*;

    localparam int CYCLE_LIMIT      = 3000000;
    localparam int RANDOM_ITEMS     = 1350;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RESET_CYCLES     = 11;
    localparam int PATTERN_CAP      = (PATTERN_MAX_DEF < PAT_BYTES) ? PATTERN_MAX_DEF : PAT_BYTES;
    localparam logic [MODE_W-1:0] MODE_RESERVED_TOP = 3'd7;
    localparam logic [79:0] SEPARATORS =
        {8'h20, 8'h2D, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF};
    localparam logic [63:0] WORD_CHARS =
        {8'h61, 8'h62, 8'h41, 8'h5A, 8'h30, 8'h39, 8'h7A, 8'h5F};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
        logic       empty;
    } subject_txn_t;

    typedef struct packed {
        logic        matched;
        logic [31:0] serial;
    } match_expect_t;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    spm_in_if  subject_if ();
    spm_out_if result_if ();

    string_pattern_match_operator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .subject   (subject_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [63:0]       pattern_words [4];
    logic [LEN_W-1:0]  pattern_len_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              negate_reg;

    logic [31:0] chain;
    logic        prev_alnum;
    logic        word_end;
    logic        found;
    logic        prefix_good;
    logic [15:0] seen_count;

    subject_txn_t  subject_queue [$];
    match_expect_t expected_matches [$];

    int mismatch_count = 0;
    int strings_ended  = 0;
    int items_queued   = 0;
    int items_accepted = 0;
    int cycle_count    = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int style_left     = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    stall_style_t stall_style = STALL_NONE;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int effective_pattern_len();
        return (pattern_len_reg > PATTERN_CAP) ? PATTERN_CAP : int'(pattern_len_reg);
    endfunction

    function automatic logic [7:0] pattern_byte_at(input int k);
        return pattern_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic logic letter_or_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void clear_string_state();
        chain       = '0;
        prev_alnum  = 1'b0;
        word_end    = 1'b0;
        found       = 1'b0;
        prefix_good = 1'b1;
        seen_count  = '0;
    endfunction

    function automatic void absorb_subject_byte(input logic [7:0] c, input int m);
        logic [31:0] eq;
        logic        alnum;
        logic        inject;
        eq = '0;
        alnum = letter_or_digit(c);
        for (int k = 0; k < m; k++)
        begin
            if (pattern_byte_at(k) == c)
                eq[k] = 1'b1;
        end
        if (int'(seen_count) < m && pattern_byte_at(int'(seen_count)) != c)
            prefix_good = 1'b0;
        inject = (mode_reg == MODE_WORD) ? !prev_alnum : 1'b1;
        chain = ((chain << 1) | {31'b0, inject}) & eq;
        if (mode_reg == MODE_WORD)
        begin
            if (word_end && !alnum)
                found = 1'b1;
            word_end = (m > 0) && chain[m - 1];
        end
        else if (m > 0 && chain[m - 1])
        begin
            found = 1'b1;
        end
        prev_alnum = alnum;
        if (seen_count != 16'hFFFF)
            seen_count = seen_count + 16'd1;
    endfunction

    function automatic logic decide_match(input logic empty, input int m);
        int   len;
        logic tail;
        len = empty ? 0 : int'(seen_count);
        tail = (m > 0) && chain[m - 1];
        if (mode_reg == MODE_WORD)
        begin
            if (m == 0)
                return !negate_reg;
            if (m > len)
                return negate_reg;
            return (found || word_end) != negate_reg;
        end
        if (empty || mode_reg > MODE_EQUALS)
            return 1'b0;
        if (mode_reg == MODE_EQUALS)
            return (len == m) ? (prefix_good != negate_reg) : 1'b0;
        if (m > len)
            return negate_reg;
        if (mode_reg == MODE_CONTAINS)
            return (m == 0 || found) != negate_reg;
        if (mode_reg == MODE_BEGINS)
            return prefix_good != negate_reg;
        return (m == 0 || tail) != negate_reg;
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic last,
                                         input logic empty);
        int            m;
        match_expect_t entry;
        m = effective_pattern_len();
        if (empty)
        begin
            clear_string_state();
            entry.matched = decide_match(1'b1, m);
        end
        else
        begin
            absorb_subject_byte(b, m);
            if (!last)
                return;
            entry.matched = decide_match(1'b0, m);
            clear_string_state();
        end
        entry.serial = strings_ended;
        strings_ended++;
        expected_matches.push_back(entry);
    endfunction

    function automatic void log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endfunction

    function automatic void queue_item(input logic [7:0] b, input logic last,
                                       input logic empty);
        subject_txn_t txn;
        txn.text_byte = b;
        txn.last      = last;
        txn.empty     = empty;
        subject_queue.push_back(txn);
        items_queued++;
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: return WORD_CHARS[$urandom_range(0, 7) * 8 +: 8];
            5:             return SEPARATORS[$urandom_range(0, 9) * 8 +: 8];
            6:             return 8'h61;
            default:       return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte(input int m);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return (m > 0) ? pattern_byte_at($urandom_range(0, m - 1)) : 8'h61;
            4, 5, 6:    return SEPARATORS[$urandom_range(0, 9) * 8 +: 8];
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_random_string(input int m);
        logic [7:0] text [72];
        int         len;
        int         pos;
        int         cut;
        int         shape;
        shape = $urandom_range(0, 19);
        if (shape == 0)
        begin
            queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        len = $urandom_range(1, m + 10);
        if (m > 0 && $urandom_range(0, 3) == 0)
            len = m;
        for (int k = 0; k < len; k++)
            text[k] = pick_text_byte(m);
        if (m > 0 && m <= len && $urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 2))
                0:       pos = 0;
                1:       pos = len - m;
                default: pos = $urandom_range(0, len - m);
            endcase
            for (int k = 0; k < m; k++)
                text[pos + k] = pattern_byte_at(k);
        end
        if (shape == 1)
        begin
            cut = $urandom_range(1, len);
            for (int k = 0; k < cut; k++)
                queue_item(text[k], 1'b0, 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        for (int k = 0; k < len; k++)
            queue_item(text[k], k == len - 1, 1'b0);
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_PAT_LOW, REG_PAT_SECOND, REG_PAT_THIRD, REG_PAT_HIGH:
                pattern_words[idx] = value;
            REG_PAT_LEN: pattern_len_reg = value[LEN_W-1:0];
            REG_MODE:    mode_reg = value[MODE_W-1:0];
            default:     negate_reg = value[0];
        endcase
    endtask

    task automatic program_matcher(input logic [63:0] w0, input logic [63:0] w1,
                                   input logic [63:0] w2, input logic [63:0] w3,
                                   input logic [63:0] len_val, input logic [63:0] mode_val,
                                   input logic [63:0] neg_val);
        write_reg(REG_PAT_LOW, w0);
        write_reg(REG_PAT_SECOND, w1);
        write_reg(REG_PAT_THIRD, w2);
        write_reg(REG_PAT_HIGH, w3);
        write_reg(REG_PAT_LEN, len_val);
        write_reg(REG_MODE, mode_val);
        write_reg(REG_NEGATE, neg_val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_random();
        logic [63:0] words [4];
        logic [63:0] len_val;
        logic [63:0] mode_val;
        logic [63:0] neg_val;
        int          sel;
        for (int k = 0; k < PAT_BYTES; k++)
            words[k / 8][(k % 8) * 8 +: 8] = pick_pattern_byte();
        len_val  = ($urandom_range(0, 1) == 0) ? 64'd0 : {$urandom, $urandom};
        mode_val = ($urandom_range(0, 1) == 0) ? 64'd0 : {$urandom, $urandom};
        neg_val  = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len_val[LEN_W-1:0] = 6'd0;
            1:       len_val[LEN_W-1:0] = 6'd1;
            2:       len_val[LEN_W-1:0] = 6'(PATTERN_CAP);
            3:       len_val[LEN_W-1:0] = 6'($urandom_range(PATTERN_CAP + 1, 63));
            4, 5:    len_val[LEN_W-1:0] = 6'($urandom_range(2, 4));
            default: len_val[LEN_W-1:0] = 6'($urandom_range(1, 8));
        endcase
        sel = $urandom_range(0, 10);
        if (sel < 10)
            mode_val[MODE_W-1:0] = 3'(sel % 5);
        else
            mode_val[MODE_W-1:0] = 3'($urandom_range(MODE_EQUALS + 1, MODE_RESERVED_TOP));
        program_matcher(words[0], words[1], words[2], words[3], len_val, mode_val, neg_val);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("string_pattern_match_operator_unit_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin : drive_subject
        subject_txn_t next_txn;
        if (!rst_n)
        begin
            subject_if.valid <= 1'b0;
        end
        else if (!subject_if.valid || subject_if.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                subject_if.valid <= 1'b0;
            end
            else if (subject_queue.size() > 0)
            begin
                next_txn = subject_queue.pop_front();
                subject_if.valid         <= 1'b1;
                subject_if.subject_byte  <= next_txn.text_byte;
                subject_if.last_byte     <= next_txn.last;
                subject_if.empty_subject <= next_txn.empty;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                subject_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = stall_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(16, 300);
            end
            else
            begin
                style_left--;
            end
            case (stall_style)
                STALL_NONE:     result_if.ready <= 1'b1;
                STALL_COIN:     result_if.ready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: result_if.ready <= (cycle_count % 5) != 0;
                default:        result_if.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        match_expect_t want;
        if (rst_n)
        begin
            if (subject_if.valid && subject_if.ready)
            begin
                predict_item(subject_if.subject_byte, subject_if.last_byte,
                             subject_if.empty_subject);
                items_accepted++;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result transaction, matched %0b",
                                           result_if.matched));
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (result_if.matched !== want.matched)
                        log_mismatch($sformatf("string %0d: matched expected %0b got %0b",
                                               want.serial, want.matched, result_if.matched));
                end
            end
        end
    end

    initial
    begin : stimulus
        int random_start;
        int phase;
        int strings;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = REG_PAT_LOW;
        cfg_data                 = '0;
        subject_if.valid         = 1'b0;
        subject_if.subject_byte  = '0;
        subject_if.last_byte     = 1'b0;
        subject_if.empty_subject = 1'b0;
        result_if.ready          = 1'b0;
        for (int k = 0; k < 4; k++)
            pattern_words[k] = '0;
        pattern_len_reg = '0;
        mode_reg        = MODE_CONTAINS;
        negate_reg      = 1'b0;
        clear_string_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: empty pattern, contains
        queue_item(8'hFF, 1'b1, 1'b1);
        queue_item(8'h00, 1'b1, 1'b0);
        wait_idle();

        // whole word "ab": bounded hit, glued miss, empty subject
        program_matcher(64'h6261, '0, '0, '0, 64'd2, 64'(MODE_WORD), 64'd0);
        queue_item(8'h2D, 1'b0, 1'b0);
        queue_item(8'h61, 1'b0, 1'b0);
        queue_item(8'h62, 1'b0, 1'b0);
        queue_item(8'h2E, 1'b1, 1'b0);
        queue_item(8'h78, 1'b0, 1'b0);
        queue_item(8'h61, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        wait_idle();

        // ends with, negated: pattern longer than subject, then a tail hit
        program_matcher(64'h6261, '0, '0, '0, 64'd2, 64'(MODE_ENDS), 64'd1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h63, 1'b0, 1'b0);
        queue_item(8'h61, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        wait_idle();

        // oversized length saturates; equals with a length mismatch
        program_matcher('1, '1, '1, '1, 64'd63, 64'(MODE_EQUALS), 64'd1);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        wait_idle();

        // unused mode code
        program_matcher('0, '0, '0, '0, 64'd0, 64'(MODE_RESERVED_TOP), 64'd1);
        queue_item(8'h61, 1'b1, 1'b0);
        wait_idle();

        // begins with: abandon a string with an empty subject, then a hit
        program_matcher(64'h6261, '0, '0, '0, 64'd2, 64'(MODE_BEGINS), 64'd0);
        queue_item(8'h61, 1'b0, 1'b0);
        queue_item(8'h62, 1'b0, 1'b0);
        queue_item(8'h55, 1'b1, 1'b1);
        queue_item(8'h61, 1'b0, 1'b0);
        queue_item(8'h62, 1'b0, 1'b0);
        queue_item(8'h7A, 1'b1, 1'b0);
        wait_idle();

        random_start = items_queued;
        phase = 0;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            wait_idle();
            program_random();
            strings = $urandom_range(4, 25);
            if (phase == 1)
            begin
                hold_requests <= hold_requests + 1;
                strings = 40;
            end
            for (int s = 0; s < strings; s++)
                queue_random_string(effective_pattern_len());
            phase++;
        end
        wait_idle();

        if (mismatch_count == 0 && expected_matches.size() == 0)
            $display("string_pattern_match_operator_unit_tb: clean");
        else
            $display("string_pattern_match_operator_unit_tb: errors");
        $finish;
    end

endmodule
